// ----- hdl/ptm_pkg.sv -----
// shared constants, codes and types of the process table manager
`timescale 1ns / 1ps
package ptm_pkg;

  localparam int TABLE_SLOTS_DEF = 64;
  localparam int PID_BITS_DEF    = 16;
  localparam int ACT_W           = 2;
  localparam int SUBJ_W          = 16;
  localparam int CHILD_W         = 17;
  localparam int CODE_W          = 32;
  localparam int OC_W            = 3;
  localparam int RS_W            = 2;

  localparam logic [ACT_W-1:0] ACT_FORK = 2'd0;
  localparam logic [ACT_W-1:0] ACT_EXIT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_KILL = 2'd2;
  localparam logic [ACT_W-1:0] ACT_WAIT = 2'd3;

  localparam logic [RS_W-1:0] RS_RUN    = 2'd0;
  localparam logic [RS_W-1:0] RS_WAIT   = 2'd1;
  localparam logic [RS_W-1:0] RS_ZOMBIE = 2'd2;

  localparam logic [OC_W-1:0] OC_OK         = 3'd0;
  localparam logic [OC_W-1:0] OC_NO_PROC    = 3'd1;
  localparam logic [OC_W-1:0] OC_ZOMBIE     = 3'd2;
  localparam logic [OC_W-1:0] OC_FULL       = 3'd3;
  localparam logic [OC_W-1:0] OC_NO_CHILD   = 3'd4;
  localparam logic [OC_W-1:0] OC_WOULDBLOCK = 3'd5;
  localparam logic [OC_W-1:0] OC_PIDS_OUT   = 3'd6;

  localparam logic [CODE_W-1:0] KILL_STATUS = 32'hFFFF_FFF7;
  localparam logic [CODE_W-1:0] NO_STATUS   = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } ptm_state_t;

  typedef struct packed {
    logic init_wr;
    logic start;
    logic rd_en;
    logic commit;
  } ptm_cmd_t;

endpackage

// ----- hdl/ptm_if.sv -----
// command and response channel interfaces
`timescale 1ns / 1ps
interface ptm_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic [ptm_pkg::ACT_W-1:0]            action;
  logic [ptm_pkg::SUBJ_W-1:0]           subject_pid;
  logic signed [ptm_pkg::CHILD_W-1:0]   wanted_child;
  logic signed [ptm_pkg::CODE_W-1:0]    exit_code;
  modport source (output valid, action, subject_pid, wanted_child, exit_code, input ready);
  modport sink   (input valid, action, subject_pid, wanted_child, exit_code, output ready);
endinterface

interface ptm_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [ptm_pkg::OC_W-1:0]             outcome;
  logic [ptm_pkg::SUBJ_W-1:0]           result_pid;
  logic signed [ptm_pkg::CODE_W-1:0]    reaped_status;
  modport source (output valid, outcome, result_pid, reaped_status, input ready);
  modport sink   (input valid, outcome, result_pid, reaped_status, output ready);
endinterface

// ----- hdl/ptm_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ptm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- hdl/ptm_ctrl.sv -----
// controller: init, accept, scan sweep, commit and output handshake
`timescale 1ns / 1ps
module ptm_ctrl #(
  parameter int TABLE_SLOTS = ptm_pkg::TABLE_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           out_ready,
  output logic                           out_valid,
  output ptm_pkg::ptm_cmd_t              cmd,
  output logic [$clog2(TABLE_SLOTS)-1:0] rd_addr
);
  import ptm_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SLOTS - 1);

  ptm_state_t state, state_next;
  logic [IDX_W-1:0] cnt;
  logic             out_free;

  assign out_free = !out_valid || out_ready;
  assign rd_addr  = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.start) begin
        cnt <= '0;
      end else if (cmd.rd_en) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (cnt == LAST) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  a_commit_free: assert property (@(posedge clk) cmd.commit |-> (!out_valid || out_ready))
    else $error("result committed over an untaken response");
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && cnt == LAST) |=> state == ST_DRAIN)
    else $error("scan did not end after the last slot");
  a_reset_init: assert property (@(posedge clk) rst |=> state == ST_INIT)
    else $error("no init after reset");
  a_accept_idle: assert property (@(posedge clk) cmd.start |-> state == ST_IDLE)
    else $error("command taken outside idle");
endmodule

// ----- hdl/ptm_dp.sv -----
// datapath: slot table, scan accumulation, decision and response register
`timescale 1ns / 1ps
module ptm_dp #(
  parameter int TABLE_SLOTS = ptm_pkg::TABLE_SLOTS_DEF,
  parameter int PID_BITS    = ptm_pkg::PID_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ptm_pkg::ptm_cmd_t                   cmd,
  input  logic [$clog2(TABLE_SLOTS)-1:0]      rd_addr,
  input  logic [ptm_pkg::ACT_W-1:0]           action,
  input  logic [ptm_pkg::SUBJ_W-1:0]          subject_pid,
  input  logic signed [ptm_pkg::CHILD_W-1:0]  wanted_child,
  input  logic signed [ptm_pkg::CODE_W-1:0]   exit_code,
  output logic [ptm_pkg::OC_W-1:0]            outcome,
  output logic [ptm_pkg::SUBJ_W-1:0]          result_pid,
  output logic signed [ptm_pkg::CODE_W-1:0]   reaped_status
);
  import ptm_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CW    = (PID_BITS > SUBJ_W) ? PID_BITS : SUBJ_W;
  localparam int WW    = CODE_W + RS_W + SUBJ_W + PID_BITS;

  // word layout: exit value, run state, parent, pid
  typedef struct packed {
    logic [CODE_W-1:0]   exitv;
    logic [RS_W-1:0]     rs;
    logic [SUBJ_W-1:0]   parent;
    logic [PID_BITS-1:0] pid;
  } slot_t;

  logic [TABLE_SLOTS-1:0] used;
  logic [PID_BITS-1:0]    pid_ctr;

  logic [ACT_W-1:0]   act_q;
  logic [SUBJ_W-1:0]  subj_q;
  logic [CHILD_W-1:0] want_q;
  logic [CODE_W-1:0]  code_q;

  logic             vld_d;
  logic [IDX_W-1:0] idx_d;
  slot_t            rword;
  logic [WW-1:0]    rdata;

  logic                p_found;
  slot_t               p_word;
  logic                f_found;
  logic [IDX_W-1:0]    f_idx;
  logic                have_child;
  logic                pick_found;
  logic [IDX_W-1:0]    pick_idx;
  logic [PID_BITS-1:0] pick_pid;
  logic [CODE_W-1:0]   pick_exit;

  logic                we;
  logic [IDX_W-1:0]    waddr;
  slot_t               wword;
  logic                c_we;
  logic [IDX_W-1:0]    c_addr;
  slot_t               c_word;
  logic                c_set;
  logic                c_clr;
  logic                c_inc;
  logic [OC_W-1:0]     c_oc;
  logic [SUBJ_W-1:0]   c_pid;
  logic [CODE_W-1:0]   c_stat;

  logic cur_used, is_parent, is_child, want_any, want_neg;

  ptm_ram #(.WIDTH(WW), .DEPTH(TABLE_SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wword),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign rword    = rdata;
  assign cur_used = used[idx_d];
  assign want_any = (want_q == {CHILD_W{1'b1}});
  assign want_neg = want_q[CHILD_W-1];
  assign is_parent = cur_used && (subj_q != '0) && (CW'(rword.pid) == CW'(subj_q));
  assign is_child  = cur_used && (rword.parent == subj_q) &&
                     (want_any || (!want_neg && CW'(rword.pid) == CW'(want_q[SUBJ_W-1:0])));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d <= 1'b0;
    end else begin
      vld_d <= cmd.rd_en;
    end
    idx_d <= rd_addr;
  end

  // command capture and scan accumulation
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      act_q      <= action;
      subj_q     <= subject_pid;
      want_q     <= wanted_child;
      code_q     <= exit_code;
      p_found    <= 1'b0;
      f_found    <= 1'b0;
      have_child <= 1'b0;
      pick_found <= 1'b0;
    end else if (vld_d) begin
      if (is_parent) begin
        p_found <= 1'b1;
        p_word  <= rword;
      end
      if (!cur_used && !f_found) begin
        f_found <= 1'b1;
        f_idx   <= idx_d;
      end
      if (is_child) begin
        have_child <= 1'b1;
        if (rword.rs == RS_ZOMBIE && (!pick_found || rword.pid < pick_pid)) begin
          pick_found <= 1'b1;
          pick_idx   <= idx_d;
          pick_pid   <= rword.pid;
          pick_exit  <= rword.exitv;
        end
      end
    end
  end

  // decision for the transaction under way
  always_comb begin
    c_we   = 1'b0;
    c_addr = '0;
    c_word = p_word;
    c_set  = 1'b0;
    c_clr  = 1'b0;
    c_inc  = 1'b0;
    c_oc   = OC_OK;
    c_pid  = '0;
    c_stat = '0;
    if (!p_found) begin
      c_oc = OC_NO_PROC;
    end else begin
      case (act_q)
        ACT_FORK: begin
          if (p_word.rs == RS_ZOMBIE) begin
            c_oc = OC_ZOMBIE;
          end else if (!f_found) begin
            c_oc = OC_FULL;
          end else if (pid_ctr == '0) begin
            c_oc = OC_PIDS_OUT;
          end else begin
            c_we          = 1'b1;
            c_addr        = f_idx;
            c_word.exitv  = NO_STATUS;
            c_word.rs     = RS_RUN;
            c_word.parent = subj_q;
            c_word.pid    = pid_ctr;
            c_set         = 1'b1;
            c_inc         = 1'b1;
            c_pid         = SUBJ_W'(pid_ctr);
          end
        end
        ACT_EXIT, ACT_KILL: begin
          if (p_word.rs == RS_ZOMBIE) begin
            c_oc = OC_ZOMBIE;
          end else begin
            c_we         = 1'b1;
            c_addr       = f_idx;
            c_word.rs    = RS_ZOMBIE;
            c_word.exitv = (act_q == ACT_KILL) ? KILL_STATUS : code_q;
          end
        end
        default: begin
          if (!have_child) begin
            c_oc      = OC_NO_CHILD;
            c_we      = (p_word.rs == RS_WAIT);
            c_word.rs = RS_RUN;
          end else if (!pick_found) begin
            c_oc      = OC_WOULDBLOCK;
            c_we      = 1'b1;
            c_word.rs = RS_WAIT;
          end else begin
            c_we      = 1'b1;
            c_word.rs = RS_RUN;
            c_clr     = 1'b1;
            c_pid     = SUBJ_W'(pick_pid);
            c_stat    = pick_exit;
          end
        end
      endcase
    end
  end

  // slot index of the parent, used as the write-back address
  logic [IDX_W-1:0] p_idx;
  always_ff @(posedge clk) begin
    if (vld_d && is_parent) begin
      p_idx <= idx_d;
    end
  end

  always_comb begin
    if (cmd.init_wr) begin
      we           = 1'b1;
      waddr        = '0;
      wword.exitv  = NO_STATUS;
      wword.rs     = RS_RUN;
      wword.parent = '0;
      wword.pid    = PID_BITS'(1);
    end else begin
      we    = cmd.commit && c_we;
      waddr = (act_q == ACT_FORK) ? c_addr : p_idx;
      wword = c_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= TABLE_SLOTS'(1);
      pid_ctr <= PID_BITS'(2);
    end else if (cmd.commit) begin
      if (c_set) begin
        used[f_idx] <= 1'b1;
      end
      if (c_clr) begin
        used[pick_idx] <= 1'b0;
      end
      if (c_inc) begin
        pid_ctr <= pid_ctr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      outcome       <= c_oc;
      result_pid    <= c_pid;
      reaped_status <= c_stat;
    end
  end
endmodule

// ----- hdl/process_table_manager_unit.sv -----
// process table manager top level
// Commands arrive on cmd_in (action, subject_pid, wanted_child, exit_code) and
// each gives exactly one response on rsp_out (outcome, result_pid,
// reaped_status), in order. A transaction is taken when valid and ready are
// both high. cmd_in is ready only while no command is in progress.
// Each command sweeps every slot of the table through the slot memory read
// port, one slot per cycle, then decides and updates the table in the commit
// state. The response turns valid as the controller returns to idle, where
// a new command can be taken. The response sits in an output register; if the
// receiver stalls, the next command is still taken and scanned, and its
// commit waits until the response register is free.
// After reset the block writes the initial process (pid 1) into slot zero in
// its init state and then takes commands; the pid counter starts at 2.
`timescale 1ns / 1ps
module process_table_manager_unit #(
  parameter int TABLE_SLOTS = ptm_pkg::TABLE_SLOTS_DEF,
  parameter int PID_BITS    = ptm_pkg::PID_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  ptm_cmd_if.sink   cmd_in,
  ptm_rsp_if.source rsp_out
);
  import ptm_pkg::*;

  ptm_cmd_t                     cmd;
  logic [$clog2(TABLE_SLOTS)-1:0] rd_addr;

  ptm_ctrl #(.TABLE_SLOTS(TABLE_SLOTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_in.valid),
    .in_ready  (cmd_in.ready),
    .out_ready (rsp_out.ready),
    .out_valid (rsp_out.valid),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  ptm_dp #(.TABLE_SLOTS(TABLE_SLOTS), .PID_BITS(PID_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .rd_addr       (rd_addr),
    .action        (cmd_in.action),
    .subject_pid   (cmd_in.subject_pid),
    .wanted_child  (cmd_in.wanted_child),
    .exit_code     (cmd_in.exit_code),
    .outcome       (rsp_out.outcome),
    .result_pid    (rsp_out.result_pid),
    .reaped_status (rsp_out.reaped_status)
  );
endmodule
